// ===== hdl/gpcm_pkg.sv =====
package gpcm_pkg;

	localparam logic [1:0] OP_PAT_BYTE  = 2'd0;
	localparam logic [1:0] OP_PAT_END   = 2'd1;
	localparam logic [1:0] OP_TEXT_BYTE = 2'd2;
	localparam logic [1:0] OP_TEXT_END  = 2'd3;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_UNFIN_ESC    = 3'd1;
	localparam logic [2:0] ST_UNCLOSED     = 3'd2;
	localparam logic [2:0] ST_BAD_ESC      = 3'd3;
	localparam logic [2:0] ST_UNESC_SPEC   = 3'd4;
	localparam logic [2:0] ST_TOO_MANY     = 3'd5;
	localparam logic [2:0] ST_NO_PATTERN   = 3'd6;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// wide enough for a command index up to the largest table size
	localparam int CMD_IDX_W = 7;

	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_ESC,
		PH_BLOCK,
		PH_BLOCK_ESC
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] byte_value;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] error_location;
		logic        match_ready;
		logic        matched;
	} res_item_t;

	typedef struct packed {
		logic                 wr;
		logic [CMD_IDX_W-1:0] idx;
		logic                 open;
		logic                 many;
		logic                 fill;
		logic                 put;
		logic [7:0]           byte_value;
	} cell_wr_t;

	typedef struct packed {
		logic       clear;
		logic       step;
		logic [7:0] byte_value;
	} act_ctl_t;

	function automatic logic is_glob_meta(input logic [7:0] b);
		return (b == CH_STAR) || (b == CH_QUEST) || (b == CH_BSLASH) ||
			(b == CH_LBRACK) || (b == CH_RBRACK);
	endfunction

endpackage

// ===== hdl/gpcm_cell.sv =====
module gpcm_cell #(
	parameter int MY_INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gpcm_pkg::cell_wr_t cw,
	input  gpcm_pkg::act_ctl_t act,
	input  logic               used,
	input  logic               carry_in,
	input  logic               shift_in,
	output logic               closed,
	output logic               carry_out,
	output logic               shift_out
);

	localparam logic START_ACT = (MY_INDEX == 0);

	logic         many_q;
	logic         act_q;
	logic [255:0] set_q;
	logic [255:0] set_d;
	logic         mine;

	assign mine = cw.wr && (cw.idx == gpcm_pkg::CMD_IDX_W'(MY_INDEX));

	// closure of many-commands ripples in from the left neighbor
	assign closed    = act_q | carry_in;
	assign carry_out = closed & many_q & used;
	assign shift_out = closed & ~many_q & used & set_q[act.byte_value];

	always_comb begin
		set_d = set_q;
		if (cw.open) begin
			set_d = cw.fill ? '1 : '0;
		end
		if (cw.put) begin
			set_d[cw.byte_value] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mine) begin
			set_q <= set_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			many_q <= 1'b0;
			act_q  <= START_ACT;
		end else begin
			if (mine && cw.open) begin
				many_q <= cw.many;
			end
			if (act.clear) begin
				act_q <= START_ACT;
			end else if (act.step) begin
				act_q <= carry_out | shift_in;
			end
		end
	end

endmodule

// ===== hdl/gpcm_compiler.sv =====
module gpcm_compiler #(
	parameter int MAX_CMDS       = 16,
	parameter int LOCATION_WIDTH = 16,
	parameter int TOT_W          = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  gpcm_pkg::cmd_item_t       cmd,
	output gpcm_pkg::cell_wr_t        cw,
	output logic [2:0]                status_d,
	output logic [LOCATION_WIDTH-1:0] err_d,
	output logic [TOT_W-1:0]          total,
	output logic                      usable,
	output logic                      pat_clear
);

	gpcm_pkg::phase_t          phase_q, phase_d, ph;
	logic                      open_q, open_d;
	logic [TOT_W-1:0]          total_q, total_d, tot;
	logic [LOCATION_WIDTH-1:0] pos_q, pos_d, pos;
	logic [2:0]                status_q, st;
	logic [LOCATION_WIDTH-1:0] err_q, errv;
	logic                      pat_op;
	logic                      start;
	logic                      full;
	logic [7:0]                b;

	assign b      = cmd.byte_value;
	assign pat_op = (cmd.op == gpcm_pkg::OP_PAT_BYTE) || (cmd.op == gpcm_pkg::OP_PAT_END);
	assign start  = take && pat_op && !open_q;
	assign ph     = start ? gpcm_pkg::PH_NORMAL : phase_q;
	assign tot    = start ? '0 : total_q;
	assign pos    = start ? '0 : pos_q;
	assign st     = start ? gpcm_pkg::ST_OK : status_q;
	assign errv   = start ? '0 : err_q;
	assign full   = (tot >= TOT_W'(MAX_CMDS));

	assign total  = total_q;
	assign usable = !open_q && (status_q == gpcm_pkg::ST_OK);

	always_comb begin
		phase_d   = ph;
		open_d    = open_q;
		total_d   = tot;
		pos_d     = pos;
		status_d  = st;
		err_d     = errv;
		pat_clear = 1'b0;
		cw        = '0;
		cw.idx    = gpcm_pkg::CMD_IDX_W'(tot);
		cw.byte_value = b;
		if (take) begin
			case (cmd.op)
				gpcm_pkg::OP_PAT_BYTE: begin
					open_d    = 1'b1;
					pat_clear = start;
					if (st == gpcm_pkg::ST_OK) begin
						case (ph)
							gpcm_pkg::PH_NORMAL: begin
								if (b == gpcm_pkg::CH_BSLASH) begin
									phase_d = gpcm_pkg::PH_ESC;
								end else if (b == gpcm_pkg::CH_RBRACK) begin
									status_d = gpcm_pkg::ST_UNESC_SPEC;
									err_d    = pos;
								end else if (full) begin
									status_d = gpcm_pkg::ST_TOO_MANY;
									err_d    = pos;
								end else begin
									cw.wr   = 1'b1;
									cw.open = 1'b1;
									if (b == gpcm_pkg::CH_STAR) begin
										cw.many = 1'b1;
										total_d = tot + 1'b1;
									end else if (b == gpcm_pkg::CH_QUEST) begin
										cw.fill = 1'b1;
										total_d = tot + 1'b1;
									end else if (b == gpcm_pkg::CH_LBRACK) begin
										phase_d = gpcm_pkg::PH_BLOCK;
									end else begin
										cw.put  = 1'b1;
										total_d = tot + 1'b1;
									end
								end
							end
							gpcm_pkg::PH_ESC: begin
								if (!gpcm_pkg::is_glob_meta(b)) begin
									status_d = gpcm_pkg::ST_BAD_ESC;
									err_d    = pos;
								end else begin
									phase_d = gpcm_pkg::PH_NORMAL;
									if (full) begin
										status_d = gpcm_pkg::ST_TOO_MANY;
										err_d    = pos;
									end else begin
										cw.wr   = 1'b1;
										cw.open = 1'b1;
										cw.put  = 1'b1;
										total_d = tot + 1'b1;
									end
								end
							end
							gpcm_pkg::PH_BLOCK: begin
								if (b == gpcm_pkg::CH_RBRACK) begin
									total_d = tot + 1'b1;
									phase_d = gpcm_pkg::PH_NORMAL;
								end else if (b == gpcm_pkg::CH_BSLASH) begin
									phase_d = gpcm_pkg::PH_BLOCK_ESC;
								end else if (gpcm_pkg::is_glob_meta(b)) begin
									status_d = gpcm_pkg::ST_UNESC_SPEC;
									err_d    = pos;
								end else begin
									cw.wr  = 1'b1;
									cw.put = 1'b1;
								end
							end
							default: begin
								if (!gpcm_pkg::is_glob_meta(b)) begin
									status_d = gpcm_pkg::ST_BAD_ESC;
									err_d    = pos;
								end else begin
									cw.wr   = 1'b1;
									cw.put  = 1'b1;
									phase_d = gpcm_pkg::PH_BLOCK;
								end
							end
						endcase
						if (pos != '1) begin
							pos_d = pos + 1'b1;
						end
					end
				end
				gpcm_pkg::OP_PAT_END: begin
					open_d    = 1'b0;
					phase_d   = gpcm_pkg::PH_NORMAL;
					pat_clear = 1'b1;
					if (st == gpcm_pkg::ST_OK) begin
						if ((ph == gpcm_pkg::PH_ESC) || (ph == gpcm_pkg::PH_BLOCK_ESC)) begin
							status_d = gpcm_pkg::ST_UNFIN_ESC;
							err_d    = pos;
						end else if (ph == gpcm_pkg::PH_BLOCK) begin
							status_d = gpcm_pkg::ST_UNCLOSED;
							err_d    = pos;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gpcm_pkg::PH_NORMAL;
			open_q   <= 1'b0;
			total_q  <= '0;
			pos_q    <= '0;
			status_q <= gpcm_pkg::ST_NO_PATTERN;
			err_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			open_q   <= open_d;
			total_q  <= total_d;
			pos_q    <= pos_d;
			status_q <= status_d;
			err_q    <= err_d;
		end
	end

endmodule

// ===== hdl/glob_pattern_compile_match.sv =====
// An accepted item's result appears in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; a text byte steps every cell of the row at once.
// The many-command closure ripples through the cell row within that same cycle.
// Reset: no pattern (status 6), empty table, only position zero active, output empty.
// Character sets in the cells hold no reset value; they are cleared or filled as each command opens.
module glob_pattern_compile_match #(
	parameter int MAX_CMDS       = 16,
	parameter int LOCATION_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  gpcm_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output gpcm_pkg::res_item_t res
);

	localparam int TOT_W = $clog2(MAX_CMDS + 1);

	logic                      accept;
	gpcm_pkg::cell_wr_t        cw;
	gpcm_pkg::act_ctl_t        act;
	logic [2:0]                status_d;
	logic [LOCATION_WIDTH-1:0] err_d;
	logic [31:0]               err_wide;
	logic [TOT_W-1:0]          total;
	logic                      usable;
	logic                      pat_clear;
	logic [MAX_CMDS-1:0]       carry;
	logic [MAX_CMDS-1:0]       shift;
	logic [MAX_CMDS:0]         closed;
	logic                      act_last_q;
	logic                      hit;
	logic                      valid_q;
	gpcm_pkg::res_item_t       res_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = valid_q && res_stall;
	assign res_valid = valid_q;
	assign res       = res_q;

	gpcm_compiler #(
		.MAX_CMDS       (MAX_CMDS),
		.LOCATION_WIDTH (LOCATION_WIDTH),
		.TOT_W          (TOT_W)
	) u_compiler (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (accept),
		.cmd       (cmd),
		.cw        (cw),
		.status_d  (status_d),
		.err_d     (err_d),
		.total     (total),
		.usable    (usable),
		.pat_clear (pat_clear)
	);

	assign act.clear      = accept && (pat_clear || (cmd.op == gpcm_pkg::OP_TEXT_END));
	assign act.step       = accept && (cmd.op == gpcm_pkg::OP_TEXT_BYTE) && usable;
	assign act.byte_value = cmd.byte_value;

	for (genvar i = 0; i < MAX_CMDS; i++) begin : g_cell
		logic carry_in;
		logic shift_in;
		logic used;
		if (i == 0) begin : g_first
			assign carry_in = 1'b0;
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign carry_in = carry[i-1];
			assign shift_in = shift[i-1];
		end
		assign used = (total > TOT_W'(i));
		gpcm_cell #(
			.MY_INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cw        (cw),
			.act       (act),
			.used      (used),
			.carry_in  (carry_in),
			.shift_in  (shift_in),
			.closed    (closed[i]),
			.carry_out (carry[i]),
			.shift_out (shift[i])
		);
	end

	// final position, past the last cell
	assign closed[MAX_CMDS] = act_last_q | carry[MAX_CMDS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_last_q <= 1'b0;
		end else if (act.clear) begin
			act_last_q <= 1'b0;
		end else if (act.step) begin
			act_last_q <= shift[MAX_CMDS-1];
		end
	end

	assign hit      = (cmd.op == gpcm_pkg::OP_TEXT_END) && usable && closed[total];
	assign err_wide = 32'(err_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status         <= status_d;
			res_q.error_location <= err_wide[15:0];
			res_q.match_ready    <= (cmd.op == gpcm_pkg::OP_TEXT_END);
			res_q.matched        <= hit;
		end
	end

endmodule
